>>> src/dcma_pkg.sv
// Shared constants, types and control structures for the dual-channel moving average.
package dcma_pkg;

  localparam int WINDOW_DEPTH = 16;
  localparam int SAMPLE_BITS  = 12;
  localparam int POS_BITS     = $clog2(WINDOW_DEPTH);
  localparam int RAW_BITS     = 12;
  localparam int SUM_BITS     = 16;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [RAW_BITS-1:0]    raw_t;
  typedef logic [SUM_BITS-1:0]    sum_t;
  typedef logic [POS_BITS-1:0]    pos_t;

  // Write control shared by both lanes.
  typedef struct packed {
    logic load;
    logic prefill;
    pos_t pos;
  } ctl_t;

  // What one lane hands to the merging stage.
  typedef struct packed {
    raw_t latest;
    sum_t sum;
  } lane_res_t;

  typedef struct packed {
    logic have_data;
    raw_t latest_left;
    raw_t latest_right;
    sum_t smoothed_left;
    sum_t smoothed_right;
  } result_t;

endpackage

>>> src/dual_channel_moving_average.sv
// Top level of the dual-channel moving average with window prefill.
// The block takes one item per clock cycle while in_stall is low. Both channels update
// their window entry and running sum in the same cycle an item with new_sample set is
// accepted, so consecutive items never wait on each other. Results go into a two-entry
// output buffer; in_stall rises only when both entries hold results that the receiver
// has not taken, and it comes straight from a register.
module dual_channel_moving_average (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 new_sample,
  input  dcma_pkg::raw_t       sample_left,
  input  dcma_pkg::raw_t       sample_right,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 have_data,
  output dcma_pkg::raw_t       latest_left,
  output dcma_pkg::raw_t       latest_right,
  output dcma_pkg::sum_t       smoothed_left,
  output dcma_pkg::sum_t       smoothed_right
);
  import dcma_pkg::*;

  logic      primed;
  pos_t      pos;
  pos_t      pos_next;
  logic      accept;
  ctl_t      ctl;
  lane_res_t res_left;
  lane_res_t res_right;
  result_t   merged;
  result_t   out_data;
  logic      buf_full;

  assign accept = in_valid && !in_stall;
  assign in_stall = buf_full;

  always_comb begin
    if (!primed || pos == POS_BITS'(WINDOW_DEPTH - 1)) begin
      pos_next = '0;
    end else begin
      pos_next = pos + pos_t'(1);
    end
  end

  assign ctl.load    = accept && new_sample;
  assign ctl.prefill = !primed;
  assign ctl.pos     = pos_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      primed <= 1'b0;
      pos    <= '0;
    end else if (ctl.load) begin
      primed <= 1'b1;
      pos    <= pos_next;
    end
  end

  dcma_lane u_lane_left (
    .clk    (clk),
    .ctl    (ctl),
    .sample (sample_left),
    .res    (res_left)
  );

  dcma_lane u_lane_right (
    .clk    (clk),
    .ctl    (ctl),
    .sample (sample_right),
    .res    (res_right)
  );

  // Until the first sample arrives every field reads as zero.
  always_comb begin
    merged = '0;
    if (primed || ctl.load) begin
      merged.have_data      = 1'b1;
      merged.latest_left    = res_left.latest;
      merged.latest_right   = res_right.latest;
      merged.smoothed_left  = res_left.sum;
      merged.smoothed_right = res_right.sum;
    end
  end

  dcma_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (merged),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign have_data      = out_data.have_data;
  assign latest_left    = out_data.latest_left;
  assign latest_right   = out_data.latest_right;
  assign smoothed_left  = out_data.smoothed_left;
  assign smoothed_right = out_data.smoothed_right;

endmodule

>>> src/dcma_lane.sv
// One channel: sample window, running sum and latest sample.
module dcma_lane (
  input  logic              clk,
  input  dcma_pkg::ctl_t    ctl,
  input  dcma_pkg::raw_t    sample,
  output dcma_pkg::lane_res_t res
);
  import dcma_pkg::*;

  sample_t win [WINDOW_DEPTH];
  sample_t latest;
  sum_t    sum;

  sample_t v;
  sum_t    v_ext;
  sum_t    sum_next;

  assign v     = SAMPLE_BITS'(sample);
  assign v_ext = SUM_BITS'(v);

  // The first sample fills the whole window, so the sum is that value times the depth.
  always_comb begin
    if (ctl.prefill) begin
      sum_next = v_ext * SUM_BITS'(WINDOW_DEPTH);
    end else begin
      sum_next = sum - SUM_BITS'(win[ctl.pos]) + v_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      latest <= v;
      sum    <= sum_next;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        if (ctl.prefill || ctl.pos == POS_BITS'(i)) begin
          win[i] <= v;
        end
      end
    end
  end

  assign res.latest = ctl.load ? RAW_BITS'(v) : RAW_BITS'(latest);
  assign res.sum    = ctl.load ? sum_next : sum;

endmodule

>>> src/dcma_out_buf.sv
// Two-entry output buffer: output register plus skid register.
module dcma_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  dcma_pkg::result_t push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output dcma_pkg::result_t out_data
);
  import dcma_pkg::*;

  logic    skid_valid;
  result_t skid_data;
  logic    take;

  assign take = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || take) begin
        out_data  <= push_data;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= push_data;
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

endmodule

>>> tb/dual_channel_moving_average_tb.sv
// Self-checking testbench for the dual-channel moving average with window prefill.
module dual_channel_moving_average_tb;
  import dcma_pkg::*;

  localparam int RANDOM_ITEMS = 650;
  localparam int IDLE_PCT     = 22;
  localparam int QUIET_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS  = 10;

  logic   clk = 1'b0;
  logic   rst;
  logic   in_valid;
  logic   in_stall;
  logic   new_sample;
  raw_t   sample_left;
  raw_t   sample_right;
  logic   out_valid;
  logic   out_stall;
  logic   have_data;
  raw_t   latest_left;
  raw_t   latest_right;
  sum_t   smoothed_left;
  sum_t   smoothed_right;

  dual_channel_moving_average dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .new_sample     (new_sample),
    .sample_left    (sample_left),
    .sample_right   (sample_right),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .have_data      (have_data),
    .latest_left    (latest_left),
    .latest_right   (latest_right),
    .smoothed_left  (smoothed_left),
    .smoothed_right (smoothed_right)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the filter state.
  raw_t    win_left  [WINDOW_DEPTH];
  raw_t    win_right [WINDOW_DEPTH];
  pos_t    head_pos;
  bit      primed;
  sum_t    run_sum_left;
  sum_t    run_sum_right;

  result_t pending_averages[$];
  int      mismatches;
  int      quiet_cycles;
  bit      calm;

  // Set by the driver at the falling edge, read by the monitor at the rising edge.
  bit      row_typed;
  result_t row_want;

  typedef struct {
    bit      ns;
    raw_t    left;
    raw_t    right;
    int      reps;
    bit      typed;
    result_t want;
  } stim_row_t;

  // A typed expectation applies to the last repetition of its row.
  stim_row_t directed [9] = '{
    '{1'b0, 12'd0,    12'd0,    1,  1'b1, {1'b0, 12'd0, 12'd0, 16'd0, 16'd0}},
    '{1'b0, 12'd4095, 12'd4095, 1,  1'b1, {1'b0, 12'd0, 12'd0, 16'd0, 16'd0}},
    '{1'b1, 12'd4095, 12'd4095, 1,  1'b1,
      {1'b1, 12'd4095, 12'd4095, 16'd65520, 16'd65520}},
    '{1'b0, 12'd0,    12'd0,    1,  1'b1,
      {1'b1, 12'd4095, 12'd4095, 16'd65520, 16'd65520}},
    '{1'b1, 12'd0,    12'd0,    16, 1'b1, {1'b1, 12'd0, 12'd0, 16'd0, 16'd0}},
    '{1'b1, 12'hAAA,  12'h555,  1,  1'b0, '0},
    '{1'b0, 12'h555,  12'hAAA,  1,  1'b0, '0},
    '{1'b1, 12'h555,  12'hAAA,  1,  1'b0, '0},
    '{1'b1, 12'd4095, 12'd0,    1,  1'b0, '0}
  };

  function automatic result_t advance_filter(input bit ns, input raw_t l, input raw_t r);
    result_t res;
    int      i;
    if (ns) begin
      if (!primed) begin
        for (i = 0; i < WINDOW_DEPTH; i++) begin
          win_left[i]  = l;
          win_right[i] = r;
        end
        run_sum_left  = sum_t'(int'(l) * WINDOW_DEPTH);
        run_sum_right = sum_t'(int'(r) * WINDOW_DEPTH);
        head_pos      = '0;
        primed        = 1'b1;
      end else begin
        head_pos            = pos_t'((int'(head_pos) + 1) % WINDOW_DEPTH);
        run_sum_left        = run_sum_left - sum_t'(win_left[head_pos]) + sum_t'(l);
        run_sum_right       = run_sum_right - sum_t'(win_right[head_pos]) + sum_t'(r);
        win_left[head_pos]  = l;
        win_right[head_pos] = r;
      end
    end
    res = '0;
    if (primed) begin
      res = {1'b1, win_left[head_pos], win_right[head_pos], run_sum_left, run_sum_right};
    end
    return res;
  endfunction

  function automatic raw_t pick_sample();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return raw_t'($urandom_range(15));
      default: return raw_t'($urandom);
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_item(input bit ns, input raw_t l, input raw_t r,
                           input bit typed, input result_t want);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    new_sample   <= ns;
    sample_left  <= l;
    sample_right <= r;
    row_typed    = typed;
    row_want     = want;
    in_valid     <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (!rst) begin
      out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin : monitor
    result_t want;
    result_t predicted;
    bit      in_taken;
    bit      out_taken;
    in_taken  = !rst && in_valid && !in_stall;
    out_taken = !rst && out_valid && !out_stall;
    if (out_taken) begin
      if (pending_averages.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected result: have=%0d latest=%0d/%0d smoothed=%0d/%0d",
                   have_data, latest_left, latest_right, smoothed_left, smoothed_right);
        end
      end else begin
        want = pending_averages.pop_front();
        if (have_data !== want.have_data || latest_left !== want.latest_left ||
            latest_right !== want.latest_right || smoothed_left !== want.smoothed_left ||
            smoothed_right !== want.smoothed_right) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("mismatch: expected have=%0d latest=%0d/%0d smoothed=%0d/%0d",
                     want.have_data, want.latest_left, want.latest_right,
                     want.smoothed_left, want.smoothed_right);
            $display("          actual   have=%0d latest=%0d/%0d smoothed=%0d/%0d",
                     have_data, latest_left, latest_right, smoothed_left, smoothed_right);
          end
        end
      end
    end
    if (in_taken) begin
      predicted = advance_filter(new_sample, sample_left, sample_right);
      pending_averages.push_back(row_typed ? row_want : predicted);
    end
    if (rst || in_taken || out_taken) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    int  r;
    int  k;
    bit  ns;
    rst          = 1'b1;
    in_valid     = 1'b0;
    new_sample   = 1'b0;
    sample_left  = '0;
    sample_right = '0;
    out_stall    = 1'b0;
    calm         = 1'b0;
    row_typed    = 1'b0;
    row_want     = '0;
    mismatches   = 0;
    quiet_cycles = 0;
    primed       = 1'b0;
    head_pos     = '0;
    run_sum_left  = '0;
    run_sum_right = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (r = 0; r < $size(directed); r++) begin
      for (k = 0; k < directed[r].reps; k++) begin
        send_item(directed[r].ns, directed[r].left, directed[r].right,
                  directed[r].typed && (k == directed[r].reps - 1), directed[r].want);
      end
    end

    // Mostly sample pairs so the window wraps many times; polls mixed in.
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      calm = (k >= 250 && k < 400);
      ns   = ($urandom_range(99) < 75);
      send_item(ns, pick_sample(), pick_sample(), 1'b0, '0);
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (pending_averages.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_averages.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> files.f
src/dcma_pkg.sv
src/dcma_lane.sv
src/dcma_out_buf.sv
src/dual_channel_moving_average.sv
tb/dual_channel_moving_average_tb.sv
